FILE: rtl/idfl_pkg.sv
// package: widths, kind and status codes, and handshake structs for the id allocator
`timescale 1ns / 1ps

package idfl_pkg;

    // table size and origin widths
    localparam int NUM_IDS       = 256;
    localparam int LINE_BITS     = 20;
    localparam int FILE_TAG_BITS = 16;

    // derived widths
    localparam int IDX_W  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int ORIG_W = FILE_TAG_BITS + LINE_BITS;

    // fixed field widths of the channels
    localparam int KIND_W    = 2;
    localparam int REL_W     = 8;
    localparam int GRANT_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int PENDING_W = 9;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

    // controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

FILE: rtl/idfl_req_if.sv
// interface: request channel of the id allocator
`timescale 1ns / 1ps

interface idfl_req_if
    import idfl_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [REL_W-1:0]         release_id;
    logic [FILE_TAG_BITS-1:0] origin_file_tag;
    logic [LINE_BITS-1:0]     origin_line;

    modport source (
        output valid, kind, release_id, origin_file_tag, origin_line,
        input  ready
    );

    modport sink (
        input  valid, kind, release_id, origin_file_tag, origin_line,
        output ready
    );
endinterface

FILE: rtl/idfl_rsp_if.sv
// interface: result channel of the id allocator
`timescale 1ns / 1ps

interface idfl_rsp_if
    import idfl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [GRANT_W-1:0]   granted_id;
    logic [STATUS_W-1:0]  status;
    logic [PENDING_W-1:0] pending_count;

    modport source (
        output valid, granted_id, status, pending_count,
        input  ready
    );

    modport sink (
        input  valid, granted_id, status, pending_count,
        output ready
    );
endinterface

FILE: rtl/idfl_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module idfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/idfl_ctrl.sv
// controller: sequences accept and result delivery of one request
`timescale 1ns / 1ps

module idfl_ctrl
    import idfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output ctrl_cmd_t cmd,
    input  dp_sts_t   sts
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // update the table only when the result can be loaded
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/idfl_dp.sv
// datapath: live bit store, free list, high-water mark, counts and result registers
`timescale 1ns / 1ps

module idfl_dp
    import idfl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    output dp_sts_t                  sts,
    input  logic [KIND_W-1:0]        kind,
    input  logic [REL_W-1:0]         release_id,
    input  logic [FILE_TAG_BITS-1:0] origin_file_tag,
    input  logic [LINE_BITS-1:0]     origin_line,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [GRANT_W-1:0]       granted_id,
    output logic [STATUS_W-1:0]      status,
    output logic [PENDING_W-1:0]     pending_count
);

    localparam int CMP_W = (REL_W > CNT_W) ? REL_W : CNT_W;

    // state registers
    logic                 free_valid_reg, free_valid_next;
    logic [IDX_W-1:0]     free_head_reg,  free_head_next;
    logic [CNT_W-1:0]     hw_reg,         hw_next;
    logic [CNT_W-1:0]     count_reg,      count_next;

    // request held from accept to execute
    logic [KIND_W-1:0]        kind_reg;
    logic [REL_W-1:0]         rel_reg;
    logic [FILE_TAG_BITS-1:0] tag_reg;
    logic [LINE_BITS-1:0]     line_reg;

    // result of the execute cycle and output registers
    logic [IDX_W-1:0]     res_id;
    logic [STATUS_W-1:0]  res_status;
    logic                 out_valid_reg;
    logic [GRANT_W-1:0]   out_granted_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [PENDING_W-1:0] out_pending_reg;

    // memory ports
    logic                 link_wr_en;
    logic [LINK_W-1:0]    link_wr_data;
    logic [LINK_W-1:0]    link_rd_data;
    logic                 live_wr_en;
    logic [IDX_W-1:0]     live_wr_addr;
    logic                 live_wr_data;
    logic [IDX_W-1:0]     live_rd_addr;
    logic                 live_rd_data;
    logic                 orig_wr_en;
    logic [IDX_W-1:0]     alloc_id;
    logic [IDX_W-1:0]     rel_idx;

    // helpers
    logic                 hw_room;
    logic                 rel_in_range;

    // link store, read address follows the free-list head so the next link is ready
    idfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_IDS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (rel_idx),
        .wr_data (link_wr_data),
        .rd_addr (free_head_reg),
        .rd_data (link_rd_data)
    );

    // live bit store: only the bits of ids below the high-water mark are used, and each of
    // those has been written since the last flush or reset
    idfl_ram #(
        .WIDTH (1),
        .DEPTH (NUM_IDS)
    ) u_live_ram (
        .clk     (clk),
        .wr_en   (live_wr_en),
        .wr_addr (live_wr_addr),
        .wr_data (live_wr_data),
        .rd_addr (live_rd_addr),
        .rd_data (live_rd_data)
    );

    // origin store: tag and line recorded against the granted id
    idfl_ram #(
        .WIDTH (ORIG_W),
        .DEPTH (NUM_IDS)
    ) u_orig_ram (
        .clk     (clk),
        .wr_en   (orig_wr_en),
        .wr_addr (alloc_id),
        .wr_data ({tag_reg, line_reg}),
        .rd_addr (alloc_id),
        .rd_data ()
    );

    assign rel_idx      = IDX_W'(rel_reg);
    assign live_rd_addr = cmd.accept ? IDX_W'(release_id) : rel_idx;
    assign hw_room      = (hw_reg < CNT_W'(NUM_IDS));
    assign rel_in_range = (CMP_W'(rel_reg) < CMP_W'(hw_reg));
    assign alloc_id     = free_valid_reg ? free_head_reg : hw_reg[IDX_W-1:0];

    // request capture on the accept beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            rel_reg  <= release_id;
            tag_reg  <= origin_file_tag;
            line_reg <= origin_line;
        end
    end

    // request execution
    always_comb
    begin
        free_valid_next = free_valid_reg;
        free_head_next  = free_head_reg;
        hw_next         = hw_reg;
        count_next      = count_reg;
        res_id          = '0;
        res_status      = ST_OK;
        link_wr_en      = 1'b0;
        link_wr_data    = free_valid_reg ? {1'b0, free_head_reg} : LINK_W'(NUM_IDS);
        live_wr_en      = 1'b0;
        live_wr_addr    = alloc_id;
        live_wr_data    = 1'b1;
        orig_wr_en      = 1'b0;
        if (cmd.exec)
        begin
            case (kind_reg)
                KIND_ALLOC:
                begin
                    if (free_valid_reg || hw_room)
                    begin
                        if (free_valid_reg)
                        begin
                            // pop: link at the head marks the bottom when out of range
                            if (link_rd_data >= LINK_W'(NUM_IDS))
                            begin
                                free_valid_next = 1'b0;
                                free_head_next  = '0;
                            end
                            else
                            begin
                                free_head_next = link_rd_data[IDX_W-1:0];
                            end
                        end
                        else
                        begin
                            hw_next = hw_reg + CNT_W'(1);
                        end
                        live_wr_en   = 1'b1;
                        live_wr_addr = alloc_id;
                        live_wr_data = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        orig_wr_en   = 1'b1;
                        res_id       = alloc_id;
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                KIND_RELEASE:
                begin
                    if (!rel_in_range)
                    begin
                        res_status = ST_RANGE;
                    end
                    else if (!live_rd_data)
                    begin
                        res_status = ST_FREE;
                    end
                    else
                    begin
                        // push onto the free list
                        live_wr_en   = 1'b1;
                        live_wr_addr = rel_idx;
                        live_wr_data = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        link_wr_en      = 1'b1;
                        free_head_next  = rel_idx;
                        free_valid_next = 1'b1;
                    end
                end
                KIND_FLUSH:
                begin
                    free_valid_next = 1'b0;
                    free_head_next  = '0;
                    hw_next         = '0;
                    count_next      = '0;
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_valid_reg <= 1'b0;
            free_head_reg  <= '0;
            hw_reg         <= '0;
            count_reg      <= '0;
        end
        else
        begin
            free_valid_reg <= free_valid_next;
            free_head_reg  <= free_head_next;
            hw_reg         <= hw_next;
            count_reg      <= count_next;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_granted_reg <= GRANT_W'(res_id);
            out_status_reg  <= res_status;
            out_pending_reg <= PENDING_W'(count_next);
        end
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign granted_id    = out_granted_reg;
    assign status        = out_status_reg;
    assign pending_count = out_pending_reg;

endmodule

FILE: rtl/id_free_list_allocator.sv
// top level: identifier allocator with a lifo free list and high-water mark
//
//  channel | dir | fields                                           | beat
//  req     | in  | kind, release_id, origin_file_tag, origin_line   | valid & ready
//  rsp     | out | granted_id, status, pending_count                | valid & ready
//
// each request has an accept cycle, which captures the request and reads its live bit,
// and an execute cycle, which updates the table and loads the result into the output
// register; the link read at the free-list head is kept current, so a pop waits on no read
// rsp is a registered output: a new request is accepted while the last beat waits
// a stalled rsp holds the block in its execute cycle until the output register frees
// reset clears free list, high-water mark and count; live bits below the mark are rewritten
`timescale 1ns / 1ps

module id_free_list_allocator
    import idfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    idfl_req_if.sink   req,
    idfl_rsp_if.source rsp
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // controller
    idfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath
    idfl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .kind            (req.kind),
        .release_id      (req.release_id),
        .origin_file_tag (req.origin_file_tag),
        .origin_line     (req.origin_line),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .granted_id      (rsp.granted_id),
        .status          (rsp.status),
        .pending_count   (rsp.pending_count)
    );

endmodule
